// ===== design/bps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants for the box/plane side classifier
// Field widths, side codes and the structs passed between pipeline stages.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int CoordW   = 32;
  localparam int NormW    = 16;
  localparam int ProdW    = CoordW + NormW;   // one normal * coordinate product
  localparam int SumW     = ProdW + 2;        // sum of three products
  localparam int FracNorm = 14;               // Q2.14 normal fraction bits

  localparam int InDataW  = 6 * CoordW + 3 * NormW + CoordW;
  localparam int InUserW  = 6;
  localparam int OutDataW = 8;

  // Plane kinds below this value are axial
  localparam logic [2:0] AXIAL_KINDS = 3'd3;
  localparam logic [2:0] KIND_X      = 3'd0;
  localparam logic [2:0] KIND_Y      = 3'd1;
  localparam logic [2:0] KIND_Z      = 3'd2;

  // Side mask codes
  localparam logic [1:0] SIDE_FRONT = 2'd1;
  localparam logic [1:0] SIDE_BACK  = 2'd2;
  localparam logic [1:0] SIDE_BOTH  = 2'd3;

  // One input word, unpacked
  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
    logic signed [CoordW-1:0] plane_offset;
    logic [2:0]               plane_kind;
    logic [2:0]               sign_mask;
  } item_t;

  // After corner selection
  typedef struct packed {
    logic                     axial;
    logic [1:0]               axial_side;
    logic signed [NormW-1:0]  nx;
    logic signed [NormW-1:0]  ny;
    logic signed [NormW-1:0]  nz;
    logic signed [CoordW-1:0] fx;
    logic signed [CoordW-1:0] fy;
    logic signed [CoordW-1:0] fz;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] plane_d;
  } sel_t;

  // After the multipliers
  typedef struct packed {
    logic                     axial;
    logic [1:0]               axial_side;
    logic signed [ProdW-1:0]  pfx;
    logic signed [ProdW-1:0]  pfy;
    logic signed [ProdW-1:0]  pfz;
    logic signed [ProdW-1:0]  pbx;
    logic signed [ProdW-1:0]  pby;
    logic signed [ProdW-1:0]  pbz;
    logic signed [CoordW-1:0] plane_d;
  } prod_t;

  // After the adders
  typedef struct packed {
    logic                     axial;
    logic [1:0]               axial_side;
    logic signed [SumW-1:0]   dot_front;
    logic signed [SumW-1:0]   dot_back;
    logic signed [CoordW-1:0] plane_d;
  } sum_t;

endpackage

// ===== design/box_on_plane_side.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_on_plane_side: axis-aligned box against plane side classifier
// Throughput is one word per cycle; the four registered stages (select,
// multiply, add, compare) each take a new word whenever the next has room.
// Reset (rst, synchronous) empties all stages; no other state is kept.
// ----------------------------------------------------------------------------
module box_on_plane_side (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, normal_x, normal_y, normal_z,
  // plane_offset
  input  logic [bps_pkg::InDataW-1:0]   s_axis_tdata,
  // plane_kind, sign_mask
  input  logic [bps_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // side_mask, then zero fill
  output logic [bps_pkg::OutDataW-1:0]  m_axis_tdata
);

  bps_pkg::item_t item;
  bps_pkg::sel_t  sel;
  bps_pkg::sum_t  sum;
  logic           sel_valid;
  logic           sel_ready;
  logic           sum_valid;
  logic           sum_ready;
  logic [1:0]     side_mask;

  // Unpack the input word
  always_comb begin
    item.min_x        = s_axis_tdata[31:0];
    item.min_y        = s_axis_tdata[63:32];
    item.min_z        = s_axis_tdata[95:64];
    item.max_x        = s_axis_tdata[127:96];
    item.max_y        = s_axis_tdata[159:128];
    item.max_z        = s_axis_tdata[191:160];
    item.normal_x     = s_axis_tdata[207:192];
    item.normal_y     = s_axis_tdata[223:208];
    item.normal_z     = s_axis_tdata[239:224];
    item.plane_offset = s_axis_tdata[271:240];
    item.plane_kind   = s_axis_tuser[2:0];
    item.sign_mask    = s_axis_tuser[5:3];
  end

  bps_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (item),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .out_sel   (sel)
  );

  bps_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_sel    (sel),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_sum   (sum)
  );

  bps_compare u_compare (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_sum    (sum),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .side_mask (side_mask)
  );

  // Pack the output word
  assign m_axis_tdata = {{(bps_pkg::OutDataW - 2){1'b0}}, side_mask};

  // An axial plane always lands on at least one side
  a_axial_nonzero: assert property (@(posedge clk) disable iff (rst)
    sel_valid && sel.axial |-> sel.axial_side != 2'd0)
    else $error("axial classification produced an empty side mask");

  // Input back-pressure only when the whole pipe is full and the sink stalls
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && sum_valid && sel_valid)
    else $error("input stalled while the pipeline has room");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && !sel_valid && !sum_valid)
    else $error("pipeline not empty after reset");

endmodule

// ===== design/bps_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_select: first pipeline stage
// Resolves axial planes outright and picks near and far corners otherwise.
// ----------------------------------------------------------------------------
module bps_select (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bps_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output bps_pkg::sel_t  out_sel
);

  logic          valid;
  bps_pkg::sel_t sel_next;
  logic signed [bps_pkg::CoordW-1:0] lo_axis;
  logic signed [bps_pkg::CoordW-1:0] hi_axis;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // Pick the coordinate named by an axial plane
  always_comb begin
    case (in_item.plane_kind)
      bps_pkg::KIND_X: begin
        lo_axis = in_item.min_x;
        hi_axis = in_item.max_x;
      end
      bps_pkg::KIND_Y: begin
        lo_axis = in_item.min_y;
        hi_axis = in_item.max_y;
      end
      default: begin
        lo_axis = in_item.min_z;
        hi_axis = in_item.max_z;
      end
    endcase
  end

  // Classify axial planes, select corners for general ones
  always_comb begin
    sel_next.axial = in_item.plane_kind < bps_pkg::AXIAL_KINDS;
    if (in_item.plane_offset <= lo_axis) begin
      sel_next.axial_side = bps_pkg::SIDE_FRONT;
    end else if (in_item.plane_offset >= hi_axis) begin
      sel_next.axial_side = bps_pkg::SIDE_BACK;
    end else begin
      sel_next.axial_side = bps_pkg::SIDE_BOTH;
    end
    sel_next.nx   = in_item.normal_x;
    sel_next.ny   = in_item.normal_y;
    sel_next.nz   = in_item.normal_z;
    // A set sign bit means the front corner sits at the minimum
    sel_next.fx   = in_item.sign_mask[0] ? in_item.min_x : in_item.max_x;
    sel_next.bx   = in_item.sign_mask[0] ? in_item.max_x : in_item.min_x;
    sel_next.fy   = in_item.sign_mask[1] ? in_item.min_y : in_item.max_y;
    sel_next.by   = in_item.sign_mask[1] ? in_item.max_y : in_item.min_y;
    sel_next.fz   = in_item.sign_mask[2] ? in_item.min_z : in_item.max_z;
    sel_next.bz   = in_item.sign_mask[2] ? in_item.max_z : in_item.min_z;
    sel_next.plane_d = in_item.plane_offset;
  end

  // Advance the stage when downstream has room
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_sel <= sel_next;
    end
  end

endmodule

// ===== design/bps_dot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_dot: dot product stages
// Multiplies normal by both corners, then sums the three products of each.
// ----------------------------------------------------------------------------
module bps_dot (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bps_pkg::sel_t in_sel,
  output logic          out_valid,
  input  logic          out_ready,
  output bps_pkg::sum_t out_sum
);

  logic           mul_valid;
  logic           mul_ready;
  bps_pkg::prod_t prod;
  bps_pkg::prod_t prod_next;
  logic           add_valid;
  bps_pkg::sum_t  sum_next;

  assign mul_ready = !add_valid || out_ready;
  assign in_ready  = !mul_valid || mul_ready;
  assign out_valid = add_valid;

  // Form the six exact 48-bit products
  always_comb begin
    prod_next.axial      = in_sel.axial;
    prod_next.axial_side = in_sel.axial_side;
    prod_next.pfx        = in_sel.nx * in_sel.fx;
    prod_next.pfy        = in_sel.ny * in_sel.fy;
    prod_next.pfz        = in_sel.nz * in_sel.fz;
    prod_next.pbx        = in_sel.nx * in_sel.bx;
    prod_next.pby        = in_sel.ny * in_sel.by;
    prod_next.pbz        = in_sel.nz * in_sel.bz;
    prod_next.plane_d    = in_sel.plane_d;
  end

  // Sum each corner's products with two guard bits
  always_comb begin
    sum_next.axial      = prod.axial;
    sum_next.axial_side = prod.axial_side;
    sum_next.dot_front  = {{2{prod.pfx[bps_pkg::ProdW-1]}}, prod.pfx}
                        + {{2{prod.pfy[bps_pkg::ProdW-1]}}, prod.pfy}
                        + {{2{prod.pfz[bps_pkg::ProdW-1]}}, prod.pfz};
    sum_next.dot_back   = {{2{prod.pbx[bps_pkg::ProdW-1]}}, prod.pbx}
                        + {{2{prod.pby[bps_pkg::ProdW-1]}}, prod.pby}
                        + {{2{prod.pbz[bps_pkg::ProdW-1]}}, prod.pbz};
    sum_next.plane_d    = prod.plane_d;
  end

  // Multiply stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (in_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod <= prod_next;
    end
  end

  // Add stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      add_valid <= 1'b0;
    end else if (mul_ready) begin
      add_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && mul_valid) begin
      out_sum <= sum_next;
    end
  end

endmodule

// ===== design/bps_compare.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_compare: final stage and output register
// Compares both dot products with the scaled distance and holds the result.
// ----------------------------------------------------------------------------
module bps_compare (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bps_pkg::sum_t in_sum,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    side_mask
);

  logic                             valid;
  logic signed [bps_pkg::SumW-1:0] dist_scaled;
  logic                             front_hit;
  logic                             back_hit;
  logic [1:0]                       side_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // Scale Q16.16 distance to Q.30 and compare
  always_comb begin
    dist_scaled = {{(bps_pkg::SumW - bps_pkg::CoordW - bps_pkg::FracNorm)
                    {in_sum.plane_d[bps_pkg::CoordW-1]}},
                   in_sum.plane_d, {bps_pkg::FracNorm{1'b0}}};
    front_hit   = in_sum.dot_front >= dist_scaled;
    back_hit    = in_sum.dot_back < dist_scaled;
    side_next   = in_sum.axial ? in_sum.axial_side : {back_hit, front_hit};
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      side_mask <= side_next;
    end
  end

endmodule

// ===== verif/box_side_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_side_checker: predicts and checks the box/plane side classifier
// Watches both stream channels. Every accepted input word is classified here
// and its side mask queued; every accepted output word is compared against
// the oldest queued mask, and its zero fill is checked. Reports the failure
// count, the masks still outstanding, both word counts and the straddle count.
// ----------------------------------------------------------------------------
module box_side_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [bps_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic [bps_pkg::InUserW-1:0]   s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [bps_pkg::OutDataW-1:0]  m_axis_tdata,
  output int                            fail_count,
  output int                            pending,
  output int                            words_in,
  output int                            words_out,
  output int                            straddle_count
);

  // Side masks still owed by the block, oldest first
  logic [1:0] side_queue[$];

  // Classify one box against one plane with exact integer arithmetic
  function automatic logic [1:0] classify_box(
      input logic [bps_pkg::InDataW-1:0] data,
      input logic [bps_pkg::InUserW-1:0] user);
    longint     lo[3];
    longint     hi[3];
    longint     nrm[3];
    longint     plane_d;
    longint     dot_front;
    longint     dot_back;
    longint     dist_q30;
    logic [2:0] kind;
    logic [2:0] signs;
    logic [1:0] side;
    for (int i = 0; i < 3; i++) begin
      lo[i]  = $signed(data[i*bps_pkg::CoordW +: bps_pkg::CoordW]);
      hi[i]  = $signed(data[(3+i)*bps_pkg::CoordW +: bps_pkg::CoordW]);
      nrm[i] = $signed(data[6*bps_pkg::CoordW + i*bps_pkg::NormW +: bps_pkg::NormW]);
    end
    plane_d = $signed(data[6*bps_pkg::CoordW + 3*bps_pkg::NormW +: bps_pkg::CoordW]);
    kind    = user[2:0];
    signs   = user[5:3];

    // Axial plane: compare the named coordinate only, front test first
    if (kind < bps_pkg::AXIAL_KINDS) begin
      if (plane_d <= lo[kind])
        return bps_pkg::SIDE_FRONT;
      else if (plane_d >= hi[kind])
        return bps_pkg::SIDE_BACK;
      else
        return bps_pkg::SIDE_BOTH;
    end

    // General plane: sign bits pick the near and far corners
    dot_front = 0;
    dot_back  = 0;
    for (int i = 0; i < 3; i++) begin
      if (signs[i]) begin
        dot_front += nrm[i] * lo[i];
        dot_back  += nrm[i] * hi[i];
      end else begin
        dot_front += nrm[i] * hi[i];
        dot_back  += nrm[i] * lo[i];
      end
    end
    dist_q30 = plane_d * (longint'(1) << bps_pkg::FracNorm);

    side = 2'b00;
    if (dot_front >= dist_q30)
      side = side | bps_pkg::SIDE_FRONT;
    if (dot_back < dist_q30)
      side = side | bps_pkg::SIDE_BACK;
    return side;
  endfunction

  // Check output words, then queue the prediction for any new input word
  always @(posedge clk) begin
    logic [1:0] want;
    logic [1:0] got;
    if (rst) begin
      side_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        got = m_axis_tdata[1:0];
        if (got == bps_pkg::SIDE_BOTH)
          straddle_count++;
        if (side_queue.size() == 0) begin
          fail_count++;
          $error("side_mask: result %0d arrived with nothing outstanding, actual %0d",
                 words_out, got);
        end else begin
          want = side_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            $error("side_mask: result %0d expected %0d, actual %0d", words_out, want, got);
          end
        end
        if (m_axis_tdata[bps_pkg::OutDataW-1:2] !== '0) begin
          fail_count++;
          $error("zero_fill: result %0d expected 0, actual %0h", words_out,
                 m_axis_tdata[bps_pkg::OutDataW-1:2]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        words_in++;
        side_queue.push_back(classify_box(s_axis_tdata, s_axis_tuser));
      end
    end
    pending = side_queue.size();
  end

endmodule

// ===== verif/tb_box_on_plane_side.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_on_plane_side: stimulus and verdict for the box/plane side classifier
// Sends a directed set of boxes (axial planes, boundary ties, extreme values,
// inconsistent sign bits, inverted boxes, oversized normals), then random
// boxes under three pacing phases and one long output stall. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_box_on_plane_side;

  localparam int                 ONE          = 65536;        // 1.0 in Q16.16
  localparam logic signed [15:0] NORM_ONE     = 16'sd16384;   // 1.0 in Q2.14
  localparam int                 RANDOM_BOXES = 1350;
  localparam int                 HOLD_CYCLES  = 300;
  localparam int                 DRAIN_CYCLES = 20;
  localparam int                 LIMIT_CYCLES = 200000;
  localparam logic [2:0]         KIND_PLANE   = 3'd3;         // first general plane kind
  localparam logic [2:0]         KIND_LAST    = 3'd7;

  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;

  logic                                clk;
  logic                                rst;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  // min_x, min_y, min_z, max_x, max_y, max_z, normal_x, normal_y, normal_z,
  // plane_offset
  logic [bps_pkg::InDataW-1:0]         s_axis_tdata;
  // plane_kind, sign_mask
  logic [bps_pkg::InUserW-1:0]         s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  // side_mask, then zero fill
  logic [bps_pkg::OutDataW-1:0]        m_axis_tdata;

  int fail_count;
  int pending;
  int words_in;
  int words_out;
  int straddle_count;
  int src_idle_pct;
  int sink_idle_pct;
  int cycle_count;
  bit hold_request;
  bit hold_done;

  box_on_plane_side u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  box_side_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .words_in       (words_in),
    .words_out      (words_out),
    .straddle_count (straddle_count)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Random coordinate spanning +-2^(bits-1)
  function automatic logic signed [31:0] rand_coord(input int bits);
    logic signed [31:0] r;
    r = $urandom;
    return r >>> (32 - bits);
  endfunction

  // Offer one word and hold it until accepted, idling first at random
  task automatic send_box(input logic signed [31:0] min_x, min_y, min_z,
                          input logic signed [31:0] max_x, max_y, max_z,
                          input logic signed [15:0] nx, ny, nz,
                          input logic signed [31:0] offset,
                          input logic [2:0] kind, input logic [2:0] signs);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {offset, nz, ny, nx, max_z, max_y, max_x, min_z, min_y, min_x};
    s_axis_tuser  <= {signs, kind};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Random box: mostly ordered corners and plane offsets that land near the box
  task automatic send_random_box();
    logic signed [31:0] lo[3];
    logic signed [31:0] hi[3];
    logic signed [31:0] pt[3];
    logic signed [31:0] swap;
    logic signed [31:0] offset;
    logic signed [15:0] nrm[3];
    logic [2:0]         kind;
    logic [2:0]         signs;
    longint             acc;
    int                 bits;
    int                 axis;
    case ($urandom_range(3))
      0:       bits = 32;
      1:       bits = 24;
      2:       bits = 20;
      default: bits = 8;
    endcase
    kind = 3'($urandom_range(7));
    acc  = 0;
    for (int i = 0; i < 3; i++) begin
      lo[i] = rand_coord(bits);
      hi[i] = rand_coord(bits);
      if (lo[i] > hi[i] && $urandom_range(9) != 0) begin
        swap  = lo[i];
        lo[i] = hi[i];
        hi[i] = swap;
      end
      if ($urandom_range(9) == 0)
        nrm[i] = 16'($urandom);
      else
        nrm[i] = 16'($urandom_range(2 * NORM_ONE) - NORM_ONE);
      signs[i] = (nrm[i] < 0) ? 1'b1 : (nrm[i] == 0 ? 1'($urandom_range(1)) : 1'b0);
      pt[i] = 32'(lo[i] + ((longint'(hi[i]) - longint'(lo[i]))
                           * $urandom_range(1023)) / 1024);
      acc += longint'(nrm[i]) * longint'(pt[i]);
    end
    // Inconsistent sign bits now and then
    if ($urandom_range(7) == 0)
      signs = 3'($urandom);
    axis = kind % 3;
    case ($urandom_range(4))
      0:       offset = rand_coord(bits);
      1:       offset = $urandom;
      2:       offset = $urandom_range(1) ? lo[axis] : hi[axis];
      default: offset = (kind < bps_pkg::AXIAL_KINDS) ? pt[axis]
                                                      : 32'(acc >>> bps_pkg::FracNorm);
    endcase
    send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], nrm[0], nrm[1], nrm[2],
             offset, kind, signs);
  endtask

  // Output ready: random stalls, plus one long hold on request
  initial begin
    m_axis_tready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    src_idle_pct  = 28;
    sink_idle_pct = 80;
    hold_request  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Axial planes: front, ties on min and max, straddle, back
    send_box(2*ONE, 0, 0, 4*ONE, 0, 0, 0, 0, 0, ONE, bps_pkg::KIND_X, 3'b000);
    send_box(2*ONE, 0, 0, 4*ONE, 0, 0, 0, 0, 0, 2*ONE, bps_pkg::KIND_X, 3'b111);
    send_box(2*ONE, 0, 0, 4*ONE, 0, 0, 0, 0, 0, 4*ONE, bps_pkg::KIND_X, 3'b000);
    send_box(2*ONE, 0, 0, 4*ONE, 0, 0, NORM_ONE, 0, 0, 3*ONE, bps_pkg::KIND_X, 3'b010);
    send_box(0, -ONE, 0, 0, ONE, 0, 0, NORM_ONE, 0, 5*ONE, bps_pkg::KIND_Y, 3'b000);
    send_box(0, 0, CMIN, 0, 0, CMAX, 0, 0, 0, 0, bps_pkg::KIND_Z, 3'b000);
    send_box(0, 0, CMIN, 0, 0, 0, 0, 0, 0, CMIN, bps_pkg::KIND_Z, 3'b000);
    send_box(0, 0, 0, CMAX, 0, 0, 0, 0, 0, CMAX, bps_pkg::KIND_X, 3'b000);
    // Axial plane with an inverted box
    send_box(5*ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 3*ONE, bps_pkg::KIND_X, 3'b000);
    send_box(5*ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 6*ONE, bps_pkg::KIND_X, 3'b000);
    // General planes with consistent sign bits
    send_box(ONE, 0, 0, 3*ONE, 0, 0, NORM_ONE, 0, 0, 2*ONE, KIND_PLANE, 3'b000);
    send_box(ONE, 0, 0, 3*ONE, 0, 0, -NORM_ONE, 0, 0, -5*ONE, KIND_PLANE, 3'b001);
    send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, NORM_ONE >>> 1, NORM_ONE >>> 1,
             -(NORM_ONE >>> 1), ONE/4, KIND_LAST, 3'b100);
    // Inconsistent sign bits can leave neither side
    send_box(ONE, 0, 0, 3*ONE, 0, 0, NORM_ONE, 0, 0, 2*ONE, KIND_PLANE, 3'b001);
    // Exact tie on the front corner
    send_box(2*ONE, 0, 0, 2*ONE, 0, 0, NORM_ONE, 0, 0, 2*ONE, 3'd4, 3'b000);
    // Zero normal against offsets around zero
    send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, 0, 3'd5, 3'b000);
    send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, -1, 3'd5, 3'b000);
    send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, 1, 3'd6, 3'b000);
    // Oversized normals and extreme coordinates
    send_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 16'sh8000, 16'sh7fff, 16'sh8000,
             CMAX, 3'd5, 3'b101);
    send_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, NORM_ONE, NORM_ONE, NORM_ONE,
             CMIN, 3'd4, 3'b000);
    send_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, -NORM_ONE, -NORM_ONE, -NORM_ONE,
             CMAX, 3'd6, 3'b111);
    // General plane with an inverted box
    send_box(3*ONE, 3*ONE, 0, -ONE, -ONE, 0, NORM_ONE, -NORM_ONE, 0, 0, KIND_LAST, 3'b010);

    // Random boxes, sink-heavy idling first
    repeat (RANDOM_BOXES / 3) send_random_box();
    src_idle_pct  = 80;
    sink_idle_pct = 28;
    repeat (RANDOM_BOXES / 3) send_random_box();
    // Full rate, starting with a long output hold to back the pipe up
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (RANDOM_BOXES - 2 * (RANDOM_BOXES / 3)) send_random_box();
    s_axis_tvalid <= 1'b0;

    // Drain
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Classified %0d boxes against axial and general planes, %0d straddling;",
             words_in, straddle_count);
    $display("%0d results checked over three pacing phases and one long output hold.",
             words_out);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
